>>> rtl/jsu_pkg.sv
package jsu_pkg;

   typedef enum logic [2:0] {
      PH_SEEK = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX  = 3'd3,
      PH_DONE = 3'd4
   } phase_type;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U = 8'h75;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_DIGIT_MAX = 8'h39;
   localparam logic [7:0] CASE_BIT = 8'h20;

   localparam logic [31:0] DIGIT_OFS = 32'h30;
   localparam logic [31:0] ALPHA_OFS = 32'h57;
   localparam logic [31:0] UTF8_ONE_LIM = 32'h80;
   localparam logic [31:0] UTF8_TWO_LIM = 32'h800;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [1:0] UTF8_CONT = 2'b10;
   localparam logic [2:0] HEX_DIGITS = 3'd4;

   // One decoded input word: 1 to 3 result bytes sharing their flags.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] bytes;
      logic            has_byte;
      logic            string_end;
      logic            quote_found;
   } bundle_type;

endpackage

>>> rtl/jsu_front.sv
module jsu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                end_of_text,
   output logic                push,
   output jsu_pkg::bundle_type bundle
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  hex_count_ff, hex_count_in;
   logic [31:0] hex_value_ff, hex_value_in;

   logic [31:0] digit;
   logic [31:0] acc;
   logic [2:0]  cnt_next;
   logic [7:0]  esc_char;
   logic        emit;

   always_comb begin
      if (in_byte <= jsu_pkg::CH_DIGIT_MAX) begin
         digit = {24'd0, in_byte} - jsu_pkg::DIGIT_OFS;
      end else begin
         digit = {24'd0, in_byte | jsu_pkg::CASE_BIT} - jsu_pkg::ALPHA_OFS;
      end
      acc = {hex_value_ff[27:0], 4'd0} + digit;
      cnt_next = hex_count_ff + 3'd1;
   end

   always_comb begin
      case (in_byte)
         jsu_pkg::CH_N: esc_char = 8'h0A;
         jsu_pkg::CH_T: esc_char = 8'h09;
         jsu_pkg::CH_R: esc_char = 8'h0D;
         jsu_pkg::CH_B: esc_char = 8'h08;
         jsu_pkg::CH_F: esc_char = 8'h0C;
         jsu_pkg::CH_U: esc_char = 8'h00;
         default: esc_char = in_byte;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      hex_count_in = hex_count_ff;
      hex_value_in = hex_value_ff;
      emit = 1'b0;
      bundle.count = 2'd1;
      bundle.bytes = '0;
      bundle.has_byte = 1'b0;
      bundle.string_end = end_of_text;
      bundle.quote_found = 1'b1;
      case (phase_ff)
         jsu_pkg::PH_BODY: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               emit = 1'b1;
               bundle.string_end = 1'b1;
               phase_in = jsu_pkg::PH_DONE;
            end else if (in_byte == jsu_pkg::CH_BSLASH && !end_of_text) begin
               phase_in = jsu_pkg::PH_ESC;
            end else begin
               emit = 1'b1;
               bundle.has_byte = 1'b1;
               bundle.bytes[0] = in_byte;
            end
         end
         jsu_pkg::PH_ESC: begin
            if (in_byte == jsu_pkg::CH_U && !end_of_text) begin
               hex_count_in = '0;
               hex_value_in = '0;
               phase_in = jsu_pkg::PH_HEX;
            end else begin
               emit = 1'b1;
               bundle.has_byte = 1'b1;
               bundle.bytes[0] = esc_char;
               phase_in = jsu_pkg::PH_BODY;
            end
         end
         jsu_pkg::PH_HEX: begin
            hex_value_in = acc;
            hex_count_in = cnt_next;
            if (cnt_next >= jsu_pkg::HEX_DIGITS || end_of_text) begin
               emit = 1'b1;
               bundle.has_byte = 1'b1;
               if (acc < jsu_pkg::UTF8_ONE_LIM) begin
                  bundle.count = 2'd1;
                  bundle.bytes[0] = acc[7:0];
               end else if (acc < jsu_pkg::UTF8_TWO_LIM) begin
                  bundle.count = 2'd2;
                  bundle.bytes[0] = jsu_pkg::UTF8_LEAD2 | acc[13:6];
                  bundle.bytes[1] = {jsu_pkg::UTF8_CONT, acc[5:0]};
               end else begin
                  bundle.count = 2'd3;
                  bundle.bytes[0] = jsu_pkg::UTF8_LEAD3 | acc[19:12];
                  bundle.bytes[1] = {jsu_pkg::UTF8_CONT, acc[11:6]};
                  bundle.bytes[2] = {jsu_pkg::UTF8_CONT, acc[5:0]};
               end
               hex_count_in = '0;
               hex_value_in = '0;
               phase_in = jsu_pkg::PH_BODY;
            end
         end
         jsu_pkg::PH_DONE: begin
            phase_in = jsu_pkg::PH_DONE;
         end
         default: begin
            if (in_byte == jsu_pkg::CH_QUOTE) begin
               phase_in = jsu_pkg::PH_BODY;
               emit = end_of_text;
            end else begin
               emit = end_of_text;
               bundle.quote_found = 1'b0;
            end
         end
      endcase
      if (end_of_text) begin
         phase_in = jsu_pkg::PH_SEEK;
         hex_count_in = '0;
         hex_value_in = '0;
      end
      push = accept & emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_SEEK;
         hex_count_ff <= '0;
         hex_value_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hex_count_ff <= hex_count_in;
         hex_value_ff <= hex_value_in;
      end
   end

endmodule

>>> rtl/jsu_queue.sv
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  jsu_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output jsu_pkg::bundle_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   jsu_pkg::bundle_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head = mem[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop = pop & not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/jsu_back.sv
module jsu_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  jsu_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_has_byte,
   output logic                rsp_string_end,
   output logic                rsp_quote_found,
   output logic                rsp_run_last
);

   logic [1:0] idx_ff;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       has_ff, send_ff, qf_ff, last_ff;
   logic       load, is_last;

   assign is_last = (idx_ff == head.count - 2'd1);
   assign load = head_valid & (~valid_ff | ~rsp_stall);
   assign pop = load & is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff <= is_last ? 2'd0 : idx_ff + 2'd1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.bytes[idx_ff];
         has_ff <= head.has_byte;
         send_ff <= head.string_end & is_last;
         qf_ff <= head.quote_found;
         last_ff <= is_last;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_has_byte = has_ff;
   assign rsp_string_end = send_ff;
   assign rsp_quote_found = qf_ff;
   assign rsp_run_last = last_ff;

endmodule

>>> rtl/json_string_unescape_core.sv
// JSON string unescaper, one text byte per word.
//
// Request channel (req_*): one byte of text per word, req_end_of_text on the
// final byte. Bytes up to the first double quote are skipped; the string body
// is then decoded (\n \t \r \b \f, pass-through escapes, \uXXXX to 1..3 UTF-8
// bytes) until the closing quote. Every text gives exactly one response word
// with rsp_string_end set.
// Response channel (rsp_*): one decoded byte per word. rsp_run_last marks the
// last response of an input byte; rsp_has_byte = 0 flags a marker-only word.
//
// A taken request word is decoded into a queue entry, from whose head the output
// register loads response words. Throughput: one request word per cycle while
// the queue is not full; a \u escape expanding to two or three bytes holds the
// response side while the single output register drains its entry byte by byte.
// The decoder front end and the output back end are split by a small queue of
// QUEUE_DEPTH decoded entries; req_stall rises only while that queue is full.
// A stalled response word is held unchanged until taken.
// Reset: synchronous; returns the decoder to quote seek and empties the queue.
module json_string_unescape_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_string_end,
   output logic       rsp_quote_found,
   output logic       rsp_run_last
);

   logic                accept;
   logic                push;
   logic                pop;
   logic                full;
   logic                not_empty;
   jsu_pkg::bundle_type push_data;
   jsu_pkg::bundle_type head;

   // Back-pressure only from the queue, never from the response side directly.
   assign req_stall = full;
   assign accept = req_valid & ~full;

   // Front: escape state machine, one decoded entry per productive byte.
   jsu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .push        (push),
      .bundle      (push_data)
   );

   // Decouples decode from output draining.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   // Back: serializes each entry into response words.
   jsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (not_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_string_end  (rsp_string_end),
      .rsp_quote_found (rsp_quote_found),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

>>> rtl/jsu_checker.sv
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_byte,
   input logic       rsp_string_end,
   input logic       rsp_quote_found,
   input logic       rsp_run_last
);

   // Held response stays valid.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Marker-only words always close the string and carry a zero byte.
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_string_end && rsp_out_byte == 8'd0)
      else $error("marker word malformed");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_end |-> rsp_run_last)
      else $error("string end not on last word of its byte");

   a_no_quote: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_quote_found |-> !rsp_has_byte)
      else $error("byte emitted before opening quote");

   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_has_byte    (rsp_has_byte),
   .rsp_string_end  (rsp_string_end),
   .rsp_quote_found (rsp_quote_found),
   .rsp_run_last    (rsp_run_last)
);

>>> tb/sv/json_string_unescape_core_test.sv
`timescale 1ns / 100ps

module json_string_unescape_core_test;

   // one request word as queued for the driver
   typedef struct packed {
      logic [7:0] data;
      logic       eot;
      logic       hold;    // wait for all responses before presenting this word
   } req_item_type;

   // one response word as predicted
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       string_end;
      logic       quote_found;
      logic       run_last;
   } rsp_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_string_end;
   logic       rsp_quote_found;
   logic       rsp_run_last;

   req_item_type pending[$];          // words not yet taken by the block
   rsp_word_type expected_words[$];   // decoded words still owed by the block
   logic [7:0]   text_buf[$];         // text under construction
   logic         word_taken_ff = 1'b0; // request word taken at the last rising edge
   int           sent_count = 0;
   int           total_items = 1;
   int           errors = 0;

   // predictor state
   jsu_pkg::phase_type dec_phase = jsu_pkg::PH_SEEK;
   logic [2:0]  dec_digits = 3'd0;
   logic [31:0] dec_value = 32'd0;

   json_string_unescape_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_byte    (rsp_has_byte),
      .rsp_string_end  (rsp_string_end),
      .rsp_quote_found (rsp_quote_found),
      .rsp_run_last    (rsp_run_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // marker-only words carry a zero byte
   function automatic rsp_word_type make_word(input logic [7:0] b, input logic has,
                                              input logic send, input logic qf);
      rsp_word_type w;
      w.out_byte    = has ? b : 8'h00;
      w.has_byte    = has;
      w.string_end  = send;
      w.quote_found = qf;
      w.run_last    = 1'b0;
      return w;
   endfunction

   // every byte counts as a digit, no validation; wraps mod 2^32
   function automatic logic [31:0] digit_worth(input logic [7:0] b);
      if (b <= jsu_pkg::CH_DIGIT_MAX)
         return {24'd0, b} - jsu_pkg::DIGIT_OFS;
      return {24'd0, b | jsu_pkg::CASE_BIT} - jsu_pkg::ALPHA_OFS;
   endfunction

   // decode one accepted request word, queue the words it owes
   task automatic unescape_byte(input logic [7:0] b, input logic eot);
      rsp_word_type outw [3];
      int           n;
      logic [7:0]   c;
      logic [31:0]  v;
      n = 0;
      case (dec_phase)
         jsu_pkg::PH_BODY: begin
            if (b == jsu_pkg::CH_QUOTE) begin
               outw[0] = make_word(8'h00, 1'b0, 1'b1, 1'b1);
               n = 1;
               dec_phase = jsu_pkg::PH_DONE;
            end else if (b == jsu_pkg::CH_BSLASH && !eot) begin
               dec_phase = jsu_pkg::PH_ESC;
            end else begin
               // a backslash as the final byte goes out literally
               outw[0] = make_word(b, 1'b1, eot, 1'b1);
               n = 1;
            end
         end
         jsu_pkg::PH_ESC: begin
            if (b == jsu_pkg::CH_U && !eot) begin
               dec_digits = 3'd0;
               dec_value  = 32'd0;
               dec_phase  = jsu_pkg::PH_HEX;
            end else begin
               case (b)
                  jsu_pkg::CH_N: c = 8'h0A;
                  jsu_pkg::CH_T: c = 8'h09;
                  jsu_pkg::CH_R: c = 8'h0D;
                  jsu_pkg::CH_B: c = 8'h08;
                  jsu_pkg::CH_F: c = 8'h0C;
                  jsu_pkg::CH_U: c = 8'h00;   // text ended right after \u
                  default:       c = b;
               endcase
               outw[0] = make_word(c, 1'b1, eot, 1'b1);
               n = 1;
               dec_phase = jsu_pkg::PH_BODY;
            end
         end
         jsu_pkg::PH_HEX: begin
            dec_value  = (dec_value << 4) + digit_worth(b);
            dec_digits = dec_digits + 3'd1;
            if (dec_digits >= jsu_pkg::HEX_DIGITS || eot) begin
               v = dec_value;
               if (v < jsu_pkg::UTF8_ONE_LIM) begin
                  outw[0] = make_word(v[7:0], 1'b1, 1'b0, 1'b1);
                  n = 1;
               end else if (v < jsu_pkg::UTF8_TWO_LIM) begin
                  outw[0] = make_word(jsu_pkg::UTF8_LEAD2 | v[13:6], 1'b1, 1'b0, 1'b1);
                  outw[1] = make_word({jsu_pkg::UTF8_CONT, v[5:0]}, 1'b1, 1'b0, 1'b1);
                  n = 2;
               end else begin
                  outw[0] = make_word(jsu_pkg::UTF8_LEAD3 | v[19:12], 1'b1, 1'b0, 1'b1);
                  outw[1] = make_word({jsu_pkg::UTF8_CONT, v[11:6]}, 1'b1, 1'b0, 1'b1);
                  outw[2] = make_word({jsu_pkg::UTF8_CONT, v[5:0]}, 1'b1, 1'b0, 1'b1);
                  n = 3;
               end
               outw[n-1].string_end = eot;
               dec_digits = 3'd0;
               dec_value  = 32'd0;
               dec_phase  = jsu_pkg::PH_BODY;
            end
         end
         jsu_pkg::PH_DONE: begin
            // trailing bytes after the closing quote are dropped
         end
         default: begin
            if (b == jsu_pkg::CH_QUOTE) begin
               dec_phase = jsu_pkg::PH_BODY;
               if (eot) begin
                  outw[0] = make_word(8'h00, 1'b0, 1'b1, 1'b1);
                  n = 1;
               end
            end else if (eot) begin
               // no quote in the whole text
               outw[0] = make_word(8'h00, 1'b0, 1'b1, 1'b0);
               n = 1;
            end
         end
      endcase
      if (eot) begin
         dec_phase  = jsu_pkg::PH_SEEK;
         dec_digits = 3'd0;
         dec_value  = 32'd0;
      end
      if (n > 0)
         outw[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++)
         expected_words = {expected_words, outw[i]};
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] b);
      text_buf = {text_buf, b};
   endtask

   task automatic add_chars(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   // flag the last byte, optionally hold off the first one, queue the text
   task automatic end_text(input logic hold);
      req_item_type it;
      for (int i = 0; i < text_buf.size(); i++) begin
         it.data = text_buf[i];
         it.eot  = (i == text_buf.size() - 1);
         it.hold = hold && (i == 0);
         pending = {pending, it};
      end
      text_buf.delete();
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10)
         return 8'h30 + {4'd0, nib};
      return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
   endfunction

   // mostly well-formed strings with random content, some noise and cut-offs
   task automatic build_random_text();
      int         n;
      int         kind;
      logic [31:0] v;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(2)) add_byte(plain_byte());
         add_byte(jsu_pkg::CH_QUOTE);
         repeat ($urandom_range(6)) begin
            kind = $urandom_range(9);
            case (kind)
               0, 1, 2: add_byte(plain_byte());
               3: begin
                  add_byte(jsu_pkg::CH_BSLASH);
                  case ($urandom_range(4))
                     0:       add_byte(jsu_pkg::CH_N);
                     1:       add_byte(jsu_pkg::CH_T);
                     2:       add_byte(jsu_pkg::CH_R);
                     3:       add_byte(jsu_pkg::CH_B);
                     default: add_byte(jsu_pkg::CH_F);
                  endcase
               end
               4: begin
                  add_byte(jsu_pkg::CH_BSLASH);
                  add_byte(8'($urandom_range(255)));
               end
               5, 6, 7: begin
                  case ($urandom_range(2))
                     0:       v = $urandom_range(0, 'h7F);
                     1:       v = $urandom_range('h80, 'h7FF);
                     default: v = $urandom_range('h800, 'hFFFF);
                  endcase
                  add_byte(jsu_pkg::CH_BSLASH);
                  add_byte(jsu_pkg::CH_U);
                  for (int i = 3; i >= 0; i--)
                     add_byte(hex_char(v[i*4 +: 4]));
               end
               8: begin
                  // junk digits, wrapping accumulator
                  add_byte(jsu_pkg::CH_BSLASH);
                  add_byte(jsu_pkg::CH_U);
                  repeat (4) add_byte(8'($urandom_range(255)));
               end
               default: begin
                  add_byte(jsu_pkg::CH_BSLASH);
                  add_byte($urandom_range(1) ? jsu_pkg::CH_QUOTE : jsu_pkg::CH_BSLASH);
               end
            endcase
         end
         if ($urandom_range(4) != 0)
            add_byte(jsu_pkg::CH_QUOTE);
         repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
         // cut the text short somewhere
         if ($urandom_range(4) == 0) begin
            n = $urandom_range(1, text_buf.size());
            while (text_buf.size() > n)
               void'(text_buf.pop_back());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents words at the falling edge, holds them while stalled.
   // Idle mix by progress: sender 33 / receiver 49, then swapped, then none.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      logic drive;
      int   mode;
      int   send_idle;
      int   recv_idle;
      mode = (sent_count * 3) / total_items;
      send_idle = (mode == 0) ? 33 : (mode == 1) ? 49 : 0;
      recv_idle = (mode == 0) ? 49 : (mode == 1) ? 33 : 0;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && word_taken_ff)
            void'(pending.pop_front());
         drive = 1'b0;
         if (req_valid && !word_taken_ff)
            drive = 1'b1;             // stalled word stays put
         else if (pending.size() > 0) begin
            if (pending[0].hold && expected_words.size() != 0)
               drive = 1'b0;          // drain every response first
            else
               drive = ($urandom_range(99) >= send_idle);
         end
         req_valid <= drive;
         if (drive && !(req_valid && !word_taken_ff)) begin
            req_in_byte     <= pending[0].data;
            req_end_of_text <= pending[0].eot;
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: at the rising edge, predict from taken request words, then
   // check each taken response word against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         word_taken_ff <= 1'b0;
      end else begin
         word_taken_ff <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            unescape_byte(req_in_byte, req_end_of_text);
            sent_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual byte %h flags %b%b%b%b",
                        $time, rsp_out_byte, rsp_has_byte, rsp_string_end,
                        rsp_quote_found, rsp_run_last);
               errors++;
            end else begin
               w = expected_words.pop_front();
               check_field("out_byte", w.out_byte, rsp_out_byte);
               check_field("has_byte", {7'd0, w.has_byte}, {7'd0, rsp_has_byte});
               check_field("string_end", {7'd0, w.string_end}, {7'd0, rsp_string_end});
               check_field("quote_found", {7'd0, w.quote_found}, {7'd0, rsp_quote_found});
               check_field("run_last", {7'd0, w.run_last}, {7'd0, rsp_run_last});
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int texts;
      // directed texts
      add_chars("\"\\u20AC\"");   // three-byte sequence, closing quote is final byte
      end_text(1'b0);
      add_chars("x");             // no quote at all
      end_text(1'b0);
      add_chars("\"");            // opening quote as final byte
      end_text(1'b0);
      add_chars("\"\\u7");        // partial \u at end of text
      end_text(1'b0);
      add_chars("\"\\u");         // text ends on the u of \u
      end_text(1'b0);
      add_chars("\"\\");          // trailing backslash
      end_text(1'b0);
      // extremes, byte after close
      text_buf = '{jsu_pkg::CH_QUOTE, 8'h00, 8'hFF, jsu_pkg::CH_QUOTE, 8'hFF};
      end_text(1'b0);
      texts = 0;
      while (pending.size() < 370) begin
         build_random_text();
         end_text(texts == 0 || texts == 40);   // drain pauses
         texts++;
      end
      total_items = pending.size();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending.size() != 0) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (expected_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, expected_words.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2000000;
      $display("%0t: timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> json_string_unescape_core.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_core.sv
rtl/jsu_checker.sv
tb/sv/json_string_unescape_core_test.sv
